// ----- design/binary_trie_min_xor_top_assert.svh -----
// Assertion macros shared by the trie design files
`ifndef BINARY_TRIE_MIN_XOR_TOP_ASSERT_SVH
`define BINARY_TRIE_MIN_XOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BTMX_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BTMX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define BTMX_ASSERT(lbl, clk, rst_n, prop, msg)
`define BTMX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- design/btmx_pkg.sv -----
// Types and constants of the minimum-xor binary trie
package btmx_pkg;

    localparam int KEY_BITS = 31;
    localparam int TAG_BITS = 16;
    localparam int CNT_BITS = 16;
    localparam int LVL_W    = $clog2(KEY_BITS);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        op_t                 opcode;
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [TAG_BITS-1:0] found_tag;
        logic [KEY_BITS-1:0] found_key;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CK_WALK,
        ST_CK_EVAL,
        ST_UP_WALK,
        ST_UP_INC,
        ST_UP_ALLOC,
        ST_Q_ROOT_A,
        ST_Q_ROOT_B,
        ST_Q_ROOT_C,
        ST_Q_WALK,
        ST_Q_PICK,
        ST_Q_TAG,
        ST_CLR,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic    load;
        logic    init_walk;
        logic    descend;
        logic    flip;
        logic    step_lvl;
        logic    cnt_rd;
        logic    root_rd;
        logic    root_idx;
        logic    live0_cap;
        logic    cnt_wr;
        logic    cnt_dec;
        logic    tag_wr;
        logic    tag_rd;
        logic    attach;
        logic    alloc;
        logic    clear;
        logic    respond;
        status_t status;
    } cmd_t;

    typedef struct packed {
        op_t  opcode;
        logic pref_zero;
        logic pref_live;
        logic cnt_max;
        logic cnt_zero;
        logic room_ok;
        logic lvl_zero;
        logic root_empty;
        logic out_busy;
    } dp_status_t;

endpackage

// ----- design/binary_trie_min_xor_top.sv -----
// Top level of the counted binary trie with minimum-xor lookup
//
// One request at a time; each walks the trie one level per step from the top key bit down.
// Insert and remove first check the whole path (a read and an evaluation per existing level),
// then update it (a read and a count write per existing level, an allocation per newly
// allocated node). Query reads both root children, then does a count read and a pick per
// level, then reads the leaf tag; clear resets the free-node pointer and the root links.
// Each level needs the single read port of the link and count stores in turn. A result
// register holds the response, so the next request is accepted while a result still waits.
// The stores need no clearing pass after reset.
module binary_trie_min_xor_top #(
    parameter int NODE_COUNT = 8192
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  btmx_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output btmx_pkg::rsp_t  rsp
);

    btmx_pkg::cmd_t       cmd;
    btmx_pkg::dp_status_t dstat;

    btmx_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_opcode (req.opcode),
        .dstat      (dstat),
        .cmd        (cmd),
        .req_stall  (req_stall)
    );

    btmx_datapath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .dstat     (dstat),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

// ----- design/btmx_datapath.sv -----
// Trie datapath: node stores, walk registers and result register
`include "binary_trie_min_xor_top_assert.svh"

module btmx_datapath #(
    parameter int NODE_COUNT = 8192
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  btmx_pkg::req_t        req,
    input  btmx_pkg::cmd_t        cmd,
    output btmx_pkg::dp_status_t  dstat,
    input  logic                  rsp_stall,
    output logic                  rsp_valid,
    output btmx_pkg::rsp_t        rsp
);

    localparam int NB    = $clog2(NODE_COUNT);
    localparam int KB    = btmx_pkg::KEY_BITS;
    localparam int TB    = btmx_pkg::TAG_BITS;
    localparam int CW    = btmx_pkg::CNT_BITS;
    localparam int LW    = btmx_pkg::LVL_W;
    localparam logic [NB:0] NODE_LIMIT = (NB+1)'(NODE_COUNT);

    logic [2*NB-1:0] link_mem [NODE_COUNT];
    logic [CW-1:0]   cnt_mem  [NODE_COUNT];
    logic [TB-1:0]   tag_mem  [NODE_COUNT];

    logic [2*NB-1:0] link_q;
    logic [CW-1:0]   cnt_q;
    logic [TB-1:0]   tag_q;

    logic [NB:0]       nf_reg;
    logic [2*NB-1:0]   root_link_reg;
    logic              rsp_valid_reg;
    btmx_pkg::rsp_t    rsp_reg;

    btmx_pkg::op_t     op_reg;
    logic [KB-1:0]     key_reg;
    logic [TB-1:0]     tag_reg;
    logic [NB-1:0]     u_reg;
    logic              root_sel_reg;
    logic [LW-1:0]     lvl_reg;
    logic [KB-1:0]     built_reg;
    logic              live0_reg;

    logic [2*NB-1:0] link_view;
    logic            kbit;
    logic            sbit;
    logic [NB-1:0]   pref_child;
    logic [NB-1:0]   sel_child;
    logic [NB-1:0]   root_c0;
    logic [NB-1:0]   root_c1;
    logic [NB-1:0]   nf_idx;
    logic [NB-1:0]   nf_inc;
    logic [LW-1:0]   lvl_m1;
    logic [NB:0]     need;
    logic [NB:0]     free_left;
    logic [2*NB-1:0] attach_link;
    logic [2*NB-1:0] alloc_link;
    logic [NB-1:0]   cnt_rd_addr;
    logic            cnt_rd_en;
    logic [CW-1:0]   cnt_upd;
    logic            with_found;

    assign link_view  = root_sel_reg ? root_link_reg : link_q;
    assign kbit       = key_reg[lvl_reg];
    assign sbit       = kbit ^ cmd.flip;
    assign pref_child = kbit ? link_view[2*NB-1:NB] : link_view[NB-1:0];
    assign sel_child  = sbit ? link_view[2*NB-1:NB] : link_view[NB-1:0];
    assign root_c0    = root_link_reg[NB-1:0];
    assign root_c1    = root_link_reg[2*NB-1:NB];
    assign nf_idx     = nf_reg[NB-1:0];
    assign nf_inc     = nf_idx + NB'(1);
    assign lvl_m1     = lvl_reg - LW'(1);
    assign need       = {{(NB+1-LW){1'b0}}, lvl_reg} + (NB+1)'(1);
    assign free_left  = NODE_LIMIT - nf_reg;
    assign cnt_upd    = cmd.cnt_dec ? (cnt_q - CW'(1)) : (cnt_q + CW'(1));

    always_comb
    begin
        attach_link = link_view;
        if (kbit)
        begin
            attach_link[2*NB-1:NB] = nf_idx;
        end
        else
        begin
            attach_link[NB-1:0] = nf_idx;
        end
    end

    // new nodes point straight at the next node to be allocated
    always_comb
    begin
        alloc_link = '0;
        if (lvl_reg != '0)
        begin
            if (key_reg[lvl_m1])
            begin
                alloc_link[2*NB-1:NB] = nf_inc;
            end
            else
            begin
                alloc_link[NB-1:0] = nf_inc;
            end
        end
    end

    always_comb
    begin
        cnt_rd_en = cmd.descend | cmd.root_rd | cmd.cnt_rd;
        if (cmd.descend)
        begin
            cnt_rd_addr = sel_child;
        end
        else if (cmd.root_rd)
        begin
            cnt_rd_addr = cmd.root_idx ? root_c1 : root_c0;
        end
        else
        begin
            cnt_rd_addr = pref_child;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.descend)
        begin
            link_q <= link_mem[sel_child];
        end
        if (cmd.alloc)
        begin
            link_mem[nf_idx] <= alloc_link;
        end
        else if (cmd.attach && !root_sel_reg)
        begin
            link_mem[u_reg] <= attach_link;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_rd_en)
        begin
            cnt_q <= cnt_mem[cnt_rd_addr];
        end
        if (cmd.alloc)
        begin
            cnt_mem[nf_idx] <= CW'(1);
        end
        else if (cmd.cnt_wr)
        begin
            cnt_mem[u_reg] <= cnt_upd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tag_rd)
        begin
            tag_q <= tag_mem[u_reg];
        end
        if (cmd.alloc && (lvl_reg == '0))
        begin
            tag_mem[nf_idx] <= tag_reg;
        end
        else if (cmd.tag_wr)
        begin
            tag_mem[u_reg] <= tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nf_reg        <= (NB+1)'(1);
            root_link_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                nf_reg        <= (NB+1)'(1);
                root_link_reg <= '0;
            end
            else
            begin
                if (cmd.alloc)
                begin
                    nf_reg <= nf_reg + (NB+1)'(1);
                end
                if (cmd.attach && root_sel_reg)
                begin
                    root_link_reg <= attach_link;
                end
            end
            if (cmd.respond)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign with_found = (op_reg == btmx_pkg::OP_QUERY) && (cmd.status == btmx_pkg::STS_OK);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req.opcode;
            key_reg <= req.key;
            tag_reg <= req.tag;
        end
        if (cmd.init_walk)
        begin
            u_reg        <= '0;
            root_sel_reg <= 1'b1;
            lvl_reg      <= LW'(KB - 1);
            built_reg    <= '0;
        end
        else
        begin
            if (cmd.descend)
            begin
                u_reg              <= sel_child;
                root_sel_reg       <= (sel_child == '0);
                built_reg[lvl_reg] <= sbit;
            end
            if (cmd.step_lvl)
            begin
                lvl_reg <= lvl_m1;
            end
        end
        if (cmd.live0_cap)
        begin
            live0_reg <= (root_c0 != '0) && (cnt_q != '0);
        end
        if (cmd.respond)
        begin
            rsp_reg.status    <= cmd.status;
            rsp_reg.found_tag <= with_found ? tag_q : '0;
            rsp_reg.found_key <= with_found ? built_reg : '0;
        end
    end

    always_comb
    begin
        dstat.opcode     = op_reg;
        dstat.pref_zero  = (pref_child == '0);
        dstat.pref_live  = (pref_child != '0) && (cnt_q != '0);
        dstat.cnt_max    = (cnt_q == '1);
        dstat.cnt_zero   = (cnt_q == '0);
        dstat.room_ok    = (need <= free_left);
        dstat.lvl_zero   = (lvl_reg == '0);
        dstat.root_empty = !live0_reg && !((root_c1 != '0) && (cnt_q != '0));
        dstat.out_busy   = rsp_valid_reg && rsp_stall;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `BTMX_ASSERT(a_nf_range, clk, rst_n, (nf_reg != '0) && (nf_reg <= NODE_LIMIT), "next free node out of range")
    `BTMX_ASSERT(a_alloc_room, clk, rst_n, cmd.alloc |-> (nf_reg < NODE_LIMIT), "allocation beyond node store")
    `BTMX_ASSERT(a_rsp_free, clk, rst_n, cmd.respond |-> !(rsp_valid_reg && rsp_stall), "result overwritten while stalled")

endmodule

// ----- design/btmx_controller.sv -----
// Trie controller: sequences the check and update walks of insert and remove, the query walk and clear
`include "binary_trie_min_xor_top_assert.svh"

module btmx_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  btmx_pkg::op_t        req_opcode,
    input  btmx_pkg::dp_status_t dstat,
    output btmx_pkg::cmd_t       cmd,
    output logic                 req_stall
);

    btmx_pkg::state_t  state_reg;
    btmx_pkg::state_t  state_next;
    btmx_pkg::status_t status_reg;
    btmx_pkg::status_t status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= btmx_pkg::ST_IDLE;
            status_reg <= btmx_pkg::STS_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        status_next = status_reg;
        case (state_reg)
            btmx_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load      = 1'b1;
                    cmd.init_walk = 1'b1;
                    case (req_opcode)
                        btmx_pkg::OP_INSERT: state_next = btmx_pkg::ST_CK_WALK;
                        btmx_pkg::OP_REMOVE: state_next = btmx_pkg::ST_CK_WALK;
                        btmx_pkg::OP_QUERY:  state_next = btmx_pkg::ST_Q_ROOT_A;
                        btmx_pkg::OP_CLEAR:  state_next = btmx_pkg::ST_CLR;
                        default:             state_next = btmx_pkg::ST_CLR;
                    endcase
                end
            end
            // check walk: nothing is written until the whole path passes
            btmx_pkg::ST_CK_WALK:
            begin
                if (dstat.pref_zero)
                begin
                    if (dstat.opcode == btmx_pkg::OP_INSERT)
                    begin
                        if (dstat.room_ok)
                        begin
                            cmd.init_walk = 1'b1;
                            state_next    = btmx_pkg::ST_UP_WALK;
                        end
                        else
                        begin
                            status_next = btmx_pkg::STS_FULL;
                            state_next  = btmx_pkg::ST_RESP;
                        end
                    end
                    else
                    begin
                        status_next = btmx_pkg::STS_NOT_FOUND;
                        state_next  = btmx_pkg::ST_RESP;
                    end
                end
                else
                begin
                    cmd.descend = 1'b1;
                    state_next  = btmx_pkg::ST_CK_EVAL;
                end
            end
            btmx_pkg::ST_CK_EVAL:
            begin
                if ((dstat.opcode == btmx_pkg::OP_INSERT) && dstat.cnt_max)
                begin
                    status_next = btmx_pkg::STS_FULL;
                    state_next  = btmx_pkg::ST_RESP;
                end
                else if ((dstat.opcode == btmx_pkg::OP_REMOVE) && dstat.cnt_zero)
                begin
                    status_next = btmx_pkg::STS_NOT_FOUND;
                    state_next  = btmx_pkg::ST_RESP;
                end
                else if (dstat.lvl_zero)
                begin
                    cmd.init_walk = 1'b1;
                    state_next    = btmx_pkg::ST_UP_WALK;
                end
                else
                begin
                    cmd.step_lvl = 1'b1;
                    state_next   = btmx_pkg::ST_CK_WALK;
                end
            end
            btmx_pkg::ST_UP_WALK:
            begin
                if (dstat.pref_zero)
                begin
                    cmd.attach = 1'b1;
                    state_next = btmx_pkg::ST_UP_ALLOC;
                end
                else
                begin
                    cmd.descend = 1'b1;
                    state_next  = btmx_pkg::ST_UP_INC;
                end
            end
            btmx_pkg::ST_UP_INC:
            begin
                cmd.cnt_wr  = 1'b1;
                cmd.cnt_dec = (dstat.opcode == btmx_pkg::OP_REMOVE);
                if (dstat.lvl_zero)
                begin
                    cmd.tag_wr  = (dstat.opcode == btmx_pkg::OP_INSERT);
                    status_next = btmx_pkg::STS_OK;
                    state_next  = btmx_pkg::ST_RESP;
                end
                else
                begin
                    cmd.step_lvl = 1'b1;
                    state_next   = btmx_pkg::ST_UP_WALK;
                end
            end
            btmx_pkg::ST_UP_ALLOC:
            begin
                cmd.alloc = 1'b1;
                if (dstat.lvl_zero)
                begin
                    status_next = btmx_pkg::STS_OK;
                    state_next  = btmx_pkg::ST_RESP;
                end
                else
                begin
                    cmd.step_lvl = 1'b1;
                end
            end
            btmx_pkg::ST_Q_ROOT_A:
            begin
                cmd.root_rd  = 1'b1;
                cmd.root_idx = 1'b0;
                state_next   = btmx_pkg::ST_Q_ROOT_B;
            end
            btmx_pkg::ST_Q_ROOT_B:
            begin
                cmd.live0_cap = 1'b1;
                cmd.root_rd   = 1'b1;
                cmd.root_idx  = 1'b1;
                state_next    = btmx_pkg::ST_Q_ROOT_C;
            end
            btmx_pkg::ST_Q_ROOT_C:
            begin
                if (dstat.root_empty)
                begin
                    status_next = btmx_pkg::STS_EMPTY;
                    state_next  = btmx_pkg::ST_RESP;
                end
                else
                begin
                    state_next = btmx_pkg::ST_Q_WALK;
                end
            end
            btmx_pkg::ST_Q_WALK:
            begin
                cmd.cnt_rd = 1'b1;
                state_next = btmx_pkg::ST_Q_PICK;
            end
            btmx_pkg::ST_Q_PICK:
            begin
                cmd.descend = 1'b1;
                cmd.flip    = !dstat.pref_live;
                if (dstat.lvl_zero)
                begin
                    state_next = btmx_pkg::ST_Q_TAG;
                end
                else
                begin
                    cmd.step_lvl = 1'b1;
                    state_next   = btmx_pkg::ST_Q_WALK;
                end
            end
            btmx_pkg::ST_Q_TAG:
            begin
                cmd.tag_rd  = 1'b1;
                status_next = btmx_pkg::STS_OK;
                state_next  = btmx_pkg::ST_RESP;
            end
            btmx_pkg::ST_CLR:
            begin
                cmd.clear   = 1'b1;
                status_next = btmx_pkg::STS_OK;
                state_next  = btmx_pkg::ST_RESP;
            end
            btmx_pkg::ST_RESP:
            begin
                if (!dstat.out_busy)
                begin
                    cmd.respond = 1'b1;
                    cmd.status  = status_reg;
                    state_next  = btmx_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = btmx_pkg::ST_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != btmx_pkg::ST_IDLE);

    `BTMX_ASSERT_NEXT(a_req_leaves_idle, clk, rst_n, (req_valid && !req_stall), (state_reg != btmx_pkg::ST_IDLE), "accepted request left controller idle")

endmodule

// ----- bench/btmx_checker.sv -----
// Response checker for the minimum-xor trie: tracks requests, predicts responses, compares
module btmx_checker #(
    parameter int NODE_COUNT = 8192
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  btmx_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  btmx_pkg::rsp_t rsp,
    output int             failures,
    output int             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KB = btmx_pkg::KEY_BITS;
    localparam int TB = btmx_pkg::TAG_BITS;
    localparam int CB = btmx_pkg::CNT_BITS;
    localparam int NB = $clog2(NODE_COUNT);
    localparam logic [CB-1:0] COUNT_TOP = '1;

    logic [NB-1:0] link_mem  [NODE_COUNT][2];
    logic [CB-1:0] count_mem [NODE_COUNT];
    logic [TB-1:0] tag_mem   [NODE_COUNT];
    int unsigned   free_ptr;

    btmx_pkg::rsp_t predicted_rsps[$];
    int             mismatch_total = 0;
    int             queued = 0;

    assign failures = mismatch_total;
    assign pending  = queued;

    function automatic bit node_live(int unsigned n);
        return n != 0 && count_mem[n] != 0;
    endfunction

    function automatic btmx_pkg::status_t trie_insert(logic [KB-1:0] key, logic [TB-1:0] tag);
        int unsigned u;
        int unsigned missing;
        int unsigned n;
        bit          sat;
        logic        c;
        u       = 0;
        missing = 0;
        sat     = 1'b0;
        for (int b = KB - 1; b >= 0; b--)
        begin
            c = key[b];
            if (missing == 0 && link_mem[u][c] != 0)
            begin
                u = link_mem[u][c];
                if (count_mem[u] == COUNT_TOP)
                    sat = 1'b1;
            end
            else
                missing++;
        end
        if (sat || free_ptr > NODE_COUNT || missing > NODE_COUNT - free_ptr)
            return btmx_pkg::STS_FULL;
        u = 0;
        for (int b = KB - 1; b >= 0; b--)
        begin
            c = key[b];
            if (link_mem[u][c] == 0)
            begin
                n = free_ptr;
                free_ptr++;
                link_mem[n][0] = '0;
                link_mem[n][1] = '0;
                count_mem[n]   = '0;
                link_mem[u][c] = n[NB-1:0];
            end
            u = link_mem[u][c];
            count_mem[u]++;
        end
        tag_mem[u] = tag;
        return btmx_pkg::STS_OK;
    endfunction

    function automatic btmx_pkg::status_t trie_remove(logic [KB-1:0] key);
        int unsigned u;
        int unsigned v;
        u = 0;
        for (int b = KB - 1; b >= 0; b--)
        begin
            v = link_mem[u][key[b]];
            if (v == 0 || count_mem[v] == 0)
                return btmx_pkg::STS_NOT_FOUND;
            u = v;
        end
        u = 0;
        for (int b = KB - 1; b >= 0; b--)
        begin
            u = link_mem[u][key[b]];
            count_mem[u]--;
        end
        return btmx_pkg::STS_OK;
    endfunction

    function automatic btmx_pkg::rsp_t predict_response(btmx_pkg::req_t r);
        btmx_pkg::rsp_t o;
        int unsigned    u;
        logic           c;
        o = '0;
        case (r.opcode)
            btmx_pkg::OP_INSERT: o.status = trie_insert(r.key, r.tag);
            btmx_pkg::OP_REMOVE: o.status = trie_remove(r.key);
            btmx_pkg::OP_QUERY:
            begin
                if (!node_live(link_mem[0][0]) && !node_live(link_mem[0][1]))
                    o.status = btmx_pkg::STS_EMPTY;
                else
                begin
                    o.status = btmx_pkg::STS_OK;
                    u = 0;
                    for (int b = KB - 1; b >= 0; b--)
                    begin
                        c = r.key[b];
                        if (!node_live(link_mem[u][c]))
                            c = ~c;
                        u = link_mem[u][c];
                        o.found_key[b] = c;
                    end
                    o.found_tag = tag_mem[u];
                end
            end
            default:
            begin
                free_ptr       = 1;
                link_mem[0][0] = '0;
                link_mem[0][1] = '0;
                o.status       = btmx_pkg::STS_OK;
            end
        endcase
        return o;
    endfunction

    initial
    begin
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            link_mem[i][0] = '0;
            link_mem[i][1] = '0;
            count_mem[i]   = '0;
            tag_mem[i]     = '0;
        end
        free_ptr = 1;
    end

    always @(posedge clk)
    begin
        btmx_pkg::rsp_t want;
        btmx_pkg::rsp_t fresh;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (predicted_rsps.size() == 0)
                begin
                    $error("response with no request outstanding: status %0d", rsp.status);
                    mismatch_total++;
                end
                else
                begin
                    want = predicted_rsps.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        mismatch_total++;
                    end
                    if (rsp.found_tag !== want.found_tag)
                    begin
                        $error("found_tag: expected 0x%h, got 0x%h",
                               want.found_tag, rsp.found_tag);
                        mismatch_total++;
                    end
                    if (rsp.found_key !== want.found_key)
                    begin
                        $error("found_key: expected 0x%h, got 0x%h",
                               want.found_key, rsp.found_key);
                        mismatch_total++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                fresh = predict_response(req);
                predicted_rsps.insert(predicted_rsps.size(), fresh);
            end
            queued <= predicted_rsps.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
// Testbench top for the minimum-xor trie: clock, reset, request stimulus and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KB         = btmx_pkg::KEY_BITS;
    localparam int TB         = btmx_pkg::TAG_BITS;
    localparam int NODES      = 8192;
    localparam int QUIET_MAX  = 5000;
    localparam int POOL_MAX   = 24;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    btmx_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    btmx_pkg::rsp_t rsp;

    int fail_count;
    int in_flight;
    int idle_pct = 0;
    int stall_pct = 0;
    int idle_plan[4]  = '{0, 84, 0, 35};
    int stall_plan[4] = '{0, 0, 84, 35};

    logic [KB-1:0] key_pool[$];

    binary_trie_min_xor_top #(
        .NODE_COUNT(NODES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    btmx_checker #(
        .NODE_COUNT(NODES)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .failures  (fail_count),
        .pending   (in_flight)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_MAX)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb failed");
        $finish;
    end

    task automatic send_request(btmx_pkg::op_t op, logic [KB-1:0] key, logic [TB-1:0] tag);
        btmx_pkg::req_t r;
        r.opcode = op;
        r.key    = key;
        r.tag    = tag;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    function automatic logic [KB-1:0] any_key();
        return KB'($urandom());
    endfunction

    function automatic logic [KB-1:0] pool_key();
        return key_pool[$urandom_range(0, key_pool.size() - 1)];
    endfunction

    // stored key with one bit flipped and the low bits scrambled
    function automatic logic [KB-1:0] near_key();
        logic [KB-1:0] k;
        k = pool_key();
        k = k ^ (KB'(1) << $urandom_range(0, KB - 1));
        return k ^ KB'($urandom_range(0, 15));
    endfunction

    task automatic random_request();
        logic [KB-1:0] k;
        int            roll;
        int            pick;
        k    = any_key();
        roll = $urandom_range(0, 99);
        if (roll < 38)
        begin
            if (key_pool.size() != 0 && $urandom_range(0, 3) == 0)
                k = pool_key();
            else if (key_pool.size() != 0 && $urandom_range(0, 1) == 0)
                k = near_key();
            key_pool.insert(key_pool.size(), k);
            if (key_pool.size() > POOL_MAX)
                key_pool.delete($urandom_range(0, key_pool.size() - 1));
            send_request(btmx_pkg::OP_INSERT, k, TB'($urandom()));
        end
        else if (roll < 62)
        begin
            if (key_pool.size() != 0 && $urandom_range(0, 9) < 8)
            begin
                pick = $urandom_range(0, key_pool.size() - 1);
                k    = key_pool[pick];
                key_pool.delete(pick);
            end
            send_request(btmx_pkg::OP_REMOVE, k, TB'($urandom()));
        end
        else if (roll < 97)
        begin
            if (key_pool.size() != 0 && $urandom_range(0, 2) != 0)
                k = ($urandom_range(0, 1) == 0) ? pool_key() : near_key();
            send_request(btmx_pkg::OP_QUERY, k, TB'($urandom()));
        end
        else
        begin
            key_pool.delete();
            send_request(btmx_pkg::OP_CLEAR, k, TB'($urandom()));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty trie, extremes, duplicates, zero-count paths, clear
        send_request(btmx_pkg::OP_QUERY,  31'h0000_0000, 16'hFFFF);
        send_request(btmx_pkg::OP_REMOVE, 31'h7FFF_FFFF, 16'h0000);
        send_request(btmx_pkg::OP_INSERT, 31'h0000_0000, 16'h0000);
        send_request(btmx_pkg::OP_INSERT, 31'h7FFF_FFFF, 16'hFFFF);
        send_request(btmx_pkg::OP_QUERY,  31'h0000_0000, 16'h0000);
        send_request(btmx_pkg::OP_QUERY,  31'h7FFF_FFFF, 16'h0000);
        send_request(btmx_pkg::OP_QUERY,  31'h4000_0000, 16'h0000);
        send_request(btmx_pkg::OP_QUERY,  31'h3FFF_FFFF, 16'hFFFF);
        send_request(btmx_pkg::OP_INSERT, 31'h0000_0000, 16'h1234);
        send_request(btmx_pkg::OP_REMOVE, 31'h0000_0000, 16'hFFFF);
        send_request(btmx_pkg::OP_QUERY,  31'h0000_0000, 16'h0000);
        send_request(btmx_pkg::OP_REMOVE, 31'h0000_0000, 16'h0000);
        send_request(btmx_pkg::OP_REMOVE, 31'h0000_0000, 16'h0000);
        send_request(btmx_pkg::OP_QUERY,  31'h0000_0000, 16'h0000);
        send_request(btmx_pkg::OP_REMOVE, 31'h7FFF_FFFF, 16'h0000);
        send_request(btmx_pkg::OP_QUERY,  31'h5555_5555, 16'h0000);
        send_request(btmx_pkg::OP_INSERT, 31'h2AAA_AAAA, 16'hAAAA);
        send_request(btmx_pkg::OP_INSERT, 31'h5555_5555, 16'h5555);
        send_request(btmx_pkg::OP_QUERY,  31'h2AAA_AAAB, 16'h0000);
        send_request(btmx_pkg::OP_CLEAR,  any_key(), TB'($urandom()));
        send_request(btmx_pkg::OP_QUERY,  31'h2AAA_AAAA, 16'h0000);
        send_request(btmx_pkg::OP_REMOVE, 31'h5555_5555, 16'h0000);
        send_request(btmx_pkg::OP_INSERT, 31'h5555_5555, 16'h0001);
        send_request(btmx_pkg::OP_QUERY,  31'h0000_0000, 16'h0000);
        send_request(btmx_pkg::OP_CLEAR,  any_key(), TB'($urandom()));

        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = idle_plan[p];
            stall_pct = stall_plan[p];
            repeat (85) random_request();
        end

        // exhaust the node store, then work against a full trie
        idle_pct  = 0;
        stall_pct = 0;
        key_pool.delete();
        send_request(btmx_pkg::OP_CLEAR, any_key(), TB'($urandom()));
        repeat (400)
            send_request(btmx_pkg::OP_INSERT, any_key(), TB'($urandom()));
        idle_pct  = 35;
        stall_pct = 35;
        repeat (30) random_request();
        send_request(btmx_pkg::OP_CLEAR, any_key(), TB'($urandom()));
        req_valid <= 1'b0;

        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/btmx_pkg.sv
design/btmx_datapath.sv
design/btmx_controller.sv
design/binary_trie_min_xor_top.sv
bench/btmx_checker.sv
bench/tb.sv
